// ----- design/corey_pkg.sv -----
// Shared types, constants and constant tables for the three-phase Corey
// relative permeability core. No dependencies.
package corey_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TOLERANCE_LSB = 0;
    localparam int FIELD_BITS    = FRACTION_BITS + 1;
    localparam int SUM_BITS      = FIELD_BITS + 3;
    localparam int ONE_Q         = 1 << FRACTION_BITS;

    localparam int INT_Q     = 30;
    localparam int LOG_FRAC  = 24;
    localparam int EXP_BITS  = 16;
    localparam int EXP_FRAC  = 12;
    localparam int P_BITS    = $clog2(INT_Q);
    localparam int LZ_BITS   = $clog2(INT_Q + 1);
    localparam int MAG_BITS  = LZ_BITS + LOG_FRAC;
    localparam int T_BITS    = MAG_BITS + EXP_BITS - EXP_FRAC;
    localparam int N_BITS    = T_BITS - LOG_FRAC;

    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (INT_Q + DIV_STEP - 1) / DIV_STEP;
    localparam int LOG_LAT    = 2 + LOG_FRAC;
    localparam int EXP_LAT    = 4 + LOG_FRAC;
    localparam int LAT_TOTAL  = 1 + DIV_STAGES + LOG_LAT + EXP_LAT;

    localparam int NUM_PHASES    = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 3 * EXP_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_RES_A = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_RES_B = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_RES_C = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_END_A = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_END_B = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_END_C = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPO  = CFG_IDX_BITS'(6);

    localparam logic [CFG_DATA_BITS-1:0] EXPO_RESET = 48'h2000_2000_2000;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_CALC
    } t_kind;

    typedef struct packed {
        t_kind kind;
    } t_tag;

    typedef struct packed {
        logic [FIELD_BITS-1:0] sat_a;
        logic [FIELD_BITS-1:0] sat_b;
    } t_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] perm_a;
        logic [FIELD_BITS-1:0] perm_b;
        logic [FIELD_BITS-1:0] perm_c;
    } t_out;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // c_k = 2^(-2^-k) in Q30, k = 1..LOG_FRAC, packed low entry first
    function automatic logic [LOG_FRAC*INT_Q-1:0] exp_coef_table();
        logic [63:0]                c;
        logic [LOG_FRAC*INT_Q-1:0]  tab;
        c   = 64'd1 << (INT_Q - 1);
        tab = '0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            c = isqrt64(c << INT_Q);
            tab[k*INT_Q +: INT_Q] = c[INT_Q-1:0];
        end
        return tab;
    endfunction

    localparam logic [LOG_FRAC*INT_Q-1:0] EXP_COEFS = exp_coef_table();

endpackage

// ----- design/corey_div.sv -----
// Pipelined restoring divider: normalized saturation (num << 30) / den.
// Depends on corey_pkg.
module corey_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [corey_pkg::FIELD_BITS-1:0]    i_num,
    input  logic [corey_pkg::FIELD_BITS-1:0]    i_den,
    input  corey_pkg::t_tag                     i_tag,
    output logic [corey_pkg::INT_Q-1:0]         o_se,
    output corey_pkg::t_tag                     o_tag
);
    localparam int FB  = corey_pkg::FIELD_BITS;
    localparam int QB  = corey_pkg::INT_Q;
    localparam int STG = corey_pkg::DIV_STAGES;

    logic [FB:0]     r_rem [STG];
    logic [QB-1:0]   r_quo [STG];
    corey_pkg::t_tag r_tag [STG];
    logic [FB:0]     n_rem [STG];
    logic [QB-1:0]   n_quo [STG];

    // remainder stays below the divisor, so the shifted-out bit is zero
    always_comb begin
        logic [FB:0]   rem;
        logic [QB-1:0] quo;
        for (int g = 0; g < STG; g++) begin
            if (g == 0) begin
                rem = {1'b0, i_num};
                quo = '0;
            end else begin
                rem = r_rem[g-1];
                quo = r_quo[g-1];
            end
            for (int j = 0; j < corey_pkg::DIV_STEP; j++) begin
                rem = {rem[FB-1:0], 1'b0};
                if (rem >= {1'b0, i_den}) begin
                    rem = rem - {1'b0, i_den};
                    quo = {quo[QB-2:0], 1'b1};
                end else begin
                    quo = {quo[QB-2:0], 1'b0};
                end
            end
            n_rem[g] = rem;
            n_quo[g] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < STG; g++) begin
                r_rem[g] <= n_rem[g];
                r_quo[g] <= n_quo[g];
                if (g == 0) begin
                    r_tag[g] <= i_tag;
                end else begin
                    r_tag[g] <= r_tag[g-1];
                end
            end
        end
    end

    assign o_se  = r_quo[STG-1];
    assign o_tag = r_tag[STG-1];

endmodule

// ----- design/corey_log.sv -----
// Pipelined log2: leading-one detect, normalize, one squaring per stage.
// Depends on corey_pkg.
module corey_log (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [corey_pkg::INT_Q-1:0]         i_se,
    input  corey_pkg::t_tag                     i_tag,
    output logic [corey_pkg::LZ_BITS-1:0]       o_lz,
    output logic [corey_pkg::LOG_FRAC-1:0]      o_frac,
    output corey_pkg::t_tag                     o_tag
);
    localparam int QB  = corey_pkg::INT_Q;
    localparam int PB  = corey_pkg::P_BITS;
    localparam int LB  = corey_pkg::LZ_BITS;
    localparam int STG = corey_pkg::LOG_FRAC;

    logic [QB-1:0]   r_se;
    logic [PB-1:0]   r_p;
    corey_pkg::t_tag r_tag_a;
    logic [QB:0]     r_m0;
    logic [LB-1:0]   r_lz0;
    corey_pkg::t_tag r_tag_b;

    logic [QB:0]     r_m    [STG];
    logic [STG-1:0]  r_frac [STG];
    logic [LB-1:0]   r_lz   [STG];
    corey_pkg::t_tag r_tag  [STG];

    logic [QB-1:0]   n_se;
    logic [PB-1:0]   n_p;
    logic [LB-1:0]   n_lz0;
    logic [QB:0]     n_m    [STG];
    logic [STG-1:0]  n_frac [STG];

    // clamp zero to one lsb, find the leading one
    always_comb begin
        n_se = (i_se == '0) ? QB'(1) : i_se;
        n_p  = '0;
        for (int i = 0; i < QB; i++) begin
            if (n_se[i]) begin
                n_p = PB'(i);
            end
        end
        n_lz0 = LB'(QB) - LB'(r_p);
    end

    always_comb begin
        logic [2*QB+1:0] prod;
        logic [QB+1:0]   sq;
        logic [QB:0]     m;
        logic [STG-1:0]  frac;
        for (int g = 0; g < STG; g++) begin
            if (g == 0) begin
                m    = r_m0;
                frac = '0;
            end else begin
                m    = r_m[g-1];
                frac = r_frac[g-1];
            end
            prod = {{(QB+1){1'b0}}, m} * {{(QB+1){1'b0}}, m};
            sq   = prod[2*QB+1:QB];
            if (sq[QB+1]) begin
                n_m[g]    = sq[QB+1:1];
                n_frac[g] = {frac[STG-2:0], 1'b1};
            end else begin
                n_m[g]    = sq[QB:0];
                n_frac[g] = {frac[STG-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_se    <= n_se;
            r_p     <= n_p;
            r_tag_a <= i_tag;
            r_m0    <= {1'b0, r_se} << n_lz0;
            r_lz0   <= n_lz0;
            r_tag_b <= r_tag_a;
            for (int g = 0; g < STG; g++) begin
                r_m[g]    <= n_m[g];
                r_frac[g] <= n_frac[g];
                if (g == 0) begin
                    r_lz[g]  <= r_lz0;
                    r_tag[g] <= r_tag_b;
                end else begin
                    r_lz[g]  <= r_lz[g-1];
                    r_tag[g] <= r_tag[g-1];
                end
            end
        end
    end

    assign o_lz   = r_lz[STG-1];
    assign o_frac = r_frac[STG-1];
    assign o_tag  = r_tag[STG-1];

endmodule

// ----- design/corey_exp.sv -----
// Exponent scaling and pipelined exp2, then endpoint scaling and case select.
// Depends on corey_pkg.
module corey_exp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [corey_pkg::LZ_BITS-1:0]       i_lz,
    input  logic [corey_pkg::LOG_FRAC-1:0]      i_frac,
    input  corey_pkg::t_tag                     i_tag,
    input  logic [corey_pkg::EXP_BITS-1:0]      i_expo,
    input  logic [corey_pkg::FIELD_BITS-1:0]    i_kmax,
    output logic [corey_pkg::FIELD_BITS-1:0]    o_perm
);
    localparam int QB  = corey_pkg::INT_Q;
    localparam int FB  = corey_pkg::FIELD_BITS;
    localparam int MB  = corey_pkg::MAG_BITS;
    localparam int EB  = corey_pkg::EXP_BITS;
    localparam int NB  = corey_pkg::N_BITS;
    localparam int STG = corey_pkg::LOG_FRAC;
    localparam int PW  = FB + QB + 1;

    logic [MB-1:0]    r_mag;
    corey_pkg::t_tag  r_tag_m;
    logic [NB-1:0]    r_n0;
    logic [STG-1:0]   r_f0;
    corey_pkg::t_tag  r_tag_t;

    logic [QB:0]      r_r   [STG];
    logic [NB-1:0]    r_n   [STG];
    logic [STG-1:0]   r_f   [STG];
    corey_pkg::t_tag  r_tag [STG];

    logic [QB:0]      r_rs;
    corey_pkg::t_tag  r_tag_s;
    logic [FB-1:0]    r_perm;

    logic [MB+EB-1:0] n_tprod;
    logic [QB:0]      n_r [STG];
    logic [QB:0]      n_rs;
    logic [PW-1:0]    n_scaled;
    logic [FB-1:0]    n_perm;

    assign n_tprod = {{EB{1'b0}}, r_mag} * {{MB{1'b0}}, i_expo};

    // one conditional multiply by 2^(-2^-k) per stage
    always_comb begin
        logic [QB:0]      r;
        logic [STG-1:0]   f;
        logic [2*QB:0]    prod;
        for (int g = 0; g < STG; g++) begin
            if (g == 0) begin
                r = (QB+1)'(1) << QB;
                f = r_f0;
            end else begin
                r = r_r[g-1];
                f = r_f[g-1];
            end
            prod = {{QB{1'b0}}, r} *
                   {{(QB+1){1'b0}}, corey_pkg::EXP_COEFS[g*QB +: QB]};
            if (f[STG-1-g]) begin
                n_r[g] = prod[2*QB:QB];
            end else begin
                n_r[g] = r;
            end
        end
    end

    always_comb begin
        if (r_n[STG-1] > NB'(QB)) begin
            n_rs = '0;
        end else begin
            n_rs = r_r[STG-1] >> r_n[STG-1];
        end
        n_scaled = {{(QB+1){1'b0}}, i_kmax} * {{FB{1'b0}}, r_rs}
                 + (PW'(1) << (QB - 1));
        case (r_tag_s.kind)
            corey_pkg::KIND_ZERO: n_perm = '0;
            corey_pkg::KIND_FULL: n_perm = i_kmax;
            default:              n_perm = n_scaled[QB +: FB];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= {i_lz, {STG{1'b0}}} - {{(MB-STG){1'b0}}, i_frac};
            r_tag_m <= i_tag;
            r_n0    <= n_tprod[corey_pkg::EXP_FRAC+STG +: NB];
            r_f0    <= n_tprod[corey_pkg::EXP_FRAC +: STG];
            r_tag_t <= r_tag_m;
            for (int g = 0; g < STG; g++) begin
                r_r[g] <= n_r[g];
                if (g == 0) begin
                    r_n[g]   <= r_n0;
                    r_f[g]   <= r_f0;
                    r_tag[g] <= r_tag_t;
                end else begin
                    r_n[g]   <= r_n[g-1];
                    r_f[g]   <= r_f[g-1];
                    r_tag[g] <= r_tag[g-1];
                end
            end
            r_rs    <= n_rs;
            r_tag_s <= r_tag[STG-1];
            r_perm  <= n_perm;
        end
    end

    assign o_perm = r_perm;

endmodule

// ----- design/three_phase_corey_rel_perm_core.sv -----
// Top level of the three-phase Corey relative permeability core.
// Depends on corey_pkg, corey_div, corey_log and corey_exp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one cell's
//   saturations sat_a and sat_b; phase c is derived as one minus both.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns
//   perm_a, perm_b and perm_c for that cell, one result per transfer.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes residuals, endpoints and packed exponents; it is
//   always ready. Write it only while no cell is in flight.
//   Throughput: one cell per cycle while the output is not stalled. Stages
//   from input transfer to output valid: 1 classify stage, 10 divider stages
//   (3 quotient bits each), 26 log2 stages (2 normalize stages, then one
//   squaring each), 28 exp2 and scaling stages (2 exponent scaling stages, one
//   coefficient multiply each for 24, then the final shift and the endpoint scaling).
//   Reset clears the valid line and restores the register defaults.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_in_ready drops; nothing is lost or repeated.
module three_phase_corey_rel_perm_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  corey_pkg::t_in                          i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output corey_pkg::t_out                         o_out_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [corey_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [corey_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    localparam int FB  = corey_pkg::FIELD_BITS;
    localparam int SB  = corey_pkg::SUM_BITS;
    localparam int EB  = corey_pkg::EXP_BITS;
    localparam int NPH = corey_pkg::NUM_PHASES;
    localparam int LAT = corey_pkg::LAT_TOTAL;

    // configuration registers
    logic [FB-1:0]                      r_res  [NPH];
    logic [FB-1:0]                      r_kmax [NPH];
    logic [corey_pkg::CFG_DATA_BITS-1:0] r_expo;

    // pipeline valid line and the classify stage
    logic [LAT-1:0]     r_vld;
    logic [FB-1:0]      r_num [NPH];
    corey_pkg::t_tag    r_tag [NPH];

    logic               w_en;
    logic signed [SB-1:0] w_s      [NPH];
    logic signed [SB-1:0] w_rmin   [NPH];
    logic signed [SB-1:0] w_others [NPH];
    logic signed [SB-1:0] w_denom;
    logic [FB-1:0]      n_num [NPH];
    corey_pkg::t_tag    n_tag [NPH];
    logic [FB-1:0]      w_perm [NPH];

    // advance everything unless a finished result is stalled at the output
    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPH; i++) begin
                r_res[i]  <= '0;
                r_kmax[i] <= FB'(corey_pkg::ONE_Q);
            end
            r_expo <= corey_pkg::EXPO_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                corey_pkg::REG_RES_A: r_res[0]  <= i_cfg_data[FB-1:0];
                corey_pkg::REG_RES_B: r_res[1]  <= i_cfg_data[FB-1:0];
                corey_pkg::REG_RES_C: r_res[2]  <= i_cfg_data[FB-1:0];
                corey_pkg::REG_END_A: r_kmax[0] <= i_cfg_data[FB-1:0];
                corey_pkg::REG_END_B: r_kmax[1] <= i_cfg_data[FB-1:0];
                corey_pkg::REG_END_C: r_kmax[2] <= i_cfg_data[FB-1:0];
                corey_pkg::REG_EXPO:  r_expo    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify each phase: zero at or below residual or if residuals reach one,
    // endpoint at or above the top threshold, else pass the numerator to the divider
    always_comb begin
        logic signed [SB-1:0] one;
        one     = SB'(corey_pkg::ONE_Q);
        w_s[0]  = signed'({{(SB-FB){1'b0}}, i_in_data.sat_a});
        w_s[1]  = signed'({{(SB-FB){1'b0}}, i_in_data.sat_b});
        w_s[2]  = one - w_s[0] - w_s[1];
        for (int i = 0; i < NPH; i++) begin
            w_rmin[i] = signed'({{(SB-FB){1'b0}}, r_res[i]});
        end
        w_others[0] = w_rmin[1] + w_rmin[2];
        w_others[1] = w_rmin[0] + w_rmin[2];
        w_others[2] = w_rmin[0] + w_rmin[1];
        w_denom     = one - w_rmin[0] - w_rmin[1] - w_rmin[2];
        for (int i = 0; i < NPH; i++) begin
            n_num[i] = FB'(w_s[i] - w_rmin[i]);
            if (w_denom <= 0 ||
                w_s[i] <= w_rmin[i] + SB'(corey_pkg::TOLERANCE_LSB)) begin
                n_tag[i].kind = corey_pkg::KIND_ZERO;
            end else if (w_s[i] >= one - w_others[i]
                                 - SB'(corey_pkg::TOLERANCE_LSB)) begin
                n_tag[i].kind = corey_pkg::KIND_FULL;
            end else begin
                n_tag[i].kind = corey_pkg::KIND_CALC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NPH; i++) begin
                r_num[i] <= n_num[i];
                r_tag[i] <= n_tag[i];
            end
        end
    end

    // one lane per phase: divide, log2, exp2 and scale
    for (genvar p = 0; p < NPH; p++) begin : g_lane
        logic [corey_pkg::INT_Q-1:0]    w_se;
        corey_pkg::t_tag                w_tag_d;
        logic [corey_pkg::LZ_BITS-1:0]  w_lz;
        logic [corey_pkg::LOG_FRAC-1:0] w_frac;
        corey_pkg::t_tag                w_tag_l;

        corey_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_num[p]),
            .i_den  (w_denom[FB-1:0]),
            .i_tag  (r_tag[p]),
            .o_se   (w_se),
            .o_tag  (w_tag_d)
        );

        corey_log u_log (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_se   (w_se),
            .i_tag  (w_tag_d),
            .o_lz   (w_lz),
            .o_frac (w_frac),
            .o_tag  (w_tag_l)
        );

        corey_exp u_exp (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lz   (w_lz),
            .i_frac (w_frac),
            .i_tag  (w_tag_l),
            .i_expo (r_expo[p*EB +: EB]),
            .i_kmax (r_kmax[p]),
            .o_perm (w_perm[p])
        );
    end

    assign o_out_data.perm_a = w_perm[0];
    assign o_out_data.perm_b = w_perm[1];
    assign o_out_data.perm_c = w_perm[2];

endmodule

// ----- design/corey_check.sv -----
// Port-level checks for the Corey core, with the bind that attaches them.
// Depends on corey_pkg and three_phase_corey_rel_perm_core.
module corey_check (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    o_in_ready,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    input  corey_pkg::t_out                         o_out_data,
    input  logic                                    i_cfg_valid,
    input  logic                                    o_cfg_ready
);
    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a stalled output freezes intake
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind three_phase_corey_rel_perm_core corey_check u_check (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for three_phase_corey_rel_perm_core: drives cells and
// register writes over valid/ready channels and checks each result against a
// bit-exact fixed-point predictor. Depends on corey_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import corey_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  DRAIN_WAIT  = 70;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [FIELD_BITS-1:0] Q_ONE = FIELD_BITS'(ONE_Q);
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(7);

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in                      i_in_data;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out                     o_out_data;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // Predictor copy of the register file
    logic [FIELD_BITS-1:0]    res_q [NUM_PHASES];
    logic [FIELD_BITS-1:0]    kmax_q [NUM_PHASES];
    logic [CFG_DATA_BITS-1:0] expo_q;
    longint unsigned          exp_root [1:LOG_FRAC];

    t_out perm_queue [$];
    int   mismatches = 0;
    int   cycles     = 0;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   hold_cnt   = 0;

    three_phase_corey_rel_perm_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, acc, probe;
        v     = v_in;
        acc   = 0;
        probe = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= acc + probe) begin
                v   = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // Build the 2^(-2^-k) roots in Q30
    function automatic void build_roots();
        longint unsigned c;
        c = 64'd1 << (INT_Q - 1);
        for (int k = 1; k <= LOG_FRAC; k++) begin
            c = int_sqrt(c << INT_Q);
            exp_root[k] = c;
        end
    endfunction

    // se^e for se in Q30 (0 < se < 1), e in Q4.12, via log2 then exp2
    function automatic longint unsigned corey_power(input longint unsigned se,
                                                    input longint unsigned e);
        int p;
        longint unsigned m, frac, mag, t, n, f, r;
        p    = 29;
        frac = 0;
        while (p > 0 && se[p] == 1'b0) p--;
        m = se << (INT_Q - p);
        for (int k = 0; k < LOG_FRAC; k++) begin
            m    = (m * m) >> INT_Q;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        mag = (longint'(INT_Q - p) << LOG_FRAC) - frac;
        t   = (mag * e) >> EXP_FRAC;
        n   = t >> LOG_FRAC;
        f   = t & ((64'd1 << LOG_FRAC) - 1);
        r   = 64'd1 << INT_Q;
        for (int k = 1; k <= LOG_FRAC; k++) begin
            if (f[LOG_FRAC-k]) r = (r * exp_root[k]) >> INT_Q;
        end
        if (n > INT_Q) return 0;
        return r >> n;
    endfunction

    function automatic logic [FIELD_BITS-1:0] phase_level(
        input longint s, input longint rmin, input longint others,
        input longint denom, input longint unsigned kmax,
        input longint unsigned e);
        longint unsigned se, r;
        if (s <= rmin + TOLERANCE_LSB) return '0;
        if (s >= longint'(ONE_Q) - others - TOLERANCE_LSB) return kmax[FIELD_BITS-1:0];
        se = (longint'(s - rmin) << INT_Q) / denom;
        if (se == 0) se = 1;
        if (se >= (64'd1 << INT_Q)) se = (64'd1 << INT_Q) - 1;
        r = corey_power(se, e);
        r = (kmax * r + (64'd1 << (INT_Q - 1))) >> INT_Q;
        return r[FIELD_BITS-1:0];
    endfunction

    function automatic t_out predict_perms(input t_in item);
        t_out   p;
        longint sa, sb, sc, ra, rb, rc, denom;
        sa    = longint'(item.sat_a);
        sb    = longint'(item.sat_b);
        sc    = longint'(ONE_Q) - sa - sb;
        ra    = longint'(res_q[0]);
        rb    = longint'(res_q[1]);
        rc    = longint'(res_q[2]);
        denom = longint'(ONE_Q) - ra - rb - rc;
        p     = '0;
        if (denom > 0) begin
            p.perm_a = phase_level(sa, ra, rb + rc, denom, kmax_q[0], expo_q[15:0]);
            p.perm_b = phase_level(sb, rb, ra + rc, denom, kmax_q[1], expo_q[31:16]);
            p.perm_c = phase_level(sc, rc, ra + rb, denom, kmax_q[2], expo_q[47:32]);
        end
        return p;
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= hold_cnt - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (perm_queue.size() == 0) begin
                $error("result with no cell outstanding: %h", o_out_data);
                mismatches++;
            end else begin
                want = perm_queue.pop_front();
                if (o_out_data.perm_a !== want.perm_a) begin
                    $error("perm_a expected %0d got %0d", want.perm_a, o_out_data.perm_a);
                    mismatches++;
                end
                if (o_out_data.perm_b !== want.perm_b) begin
                    $error("perm_b expected %0d got %0d", want.perm_b, o_out_data.perm_b);
                    mismatches++;
                end
                if (o_out_data.perm_c !== want.perm_c) begin
                    $error("perm_c expected %0d got %0d", want.perm_c, o_out_data.perm_c);
                    mismatches++;
                end
            end
        end
    end

    // Offer one cell; entered and left at a falling edge. Valid stays high on exit.
    task automatic send_cell(input logic [FIELD_BITS-1:0] sa,
                             input logic [FIELD_BITS-1:0] sb);
        t_in item;
        item.sat_a = sa;
        item.sat_b = sb;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        perm_queue.push_back(predict_perms(item));
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every result, then let the pipeline empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (perm_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // One register transfer; valid stays high on exit
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RES_A: res_q[0]  = val[FIELD_BITS-1:0];
            REG_RES_B: res_q[1]  = val[FIELD_BITS-1:0];
            REG_RES_C: res_q[2]  = val[FIELD_BITS-1:0];
            REG_END_A: kmax_q[0] = val[FIELD_BITS-1:0];
            REG_END_B: kmax_q[1] = val[FIELD_BITS-1:0];
            REG_END_C: kmax_q[2] = val[FIELD_BITS-1:0];
            REG_EXPO:  expo_q    = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Load a full setting, plus a junk write to the unused index
    task automatic load_setting(input logic [FIELD_BITS-1:0] ra,
                                input logic [FIELD_BITS-1:0] rb,
                                input logic [FIELD_BITS-1:0] rc,
                                input logic [FIELD_BITS-1:0] ka,
                                input logic [FIELD_BITS-1:0] kb,
                                input logic [FIELD_BITS-1:0] kc,
                                input logic [CFG_DATA_BITS-1:0] ex);
        write_reg(REG_RES_A, CFG_DATA_BITS'(ra)
                             | CFG_DATA_BITS'({$urandom, $urandom} << FIELD_BITS));
        write_reg(REG_RES_B, CFG_DATA_BITS'(rb));
        write_reg(REG_RES_C, CFG_DATA_BITS'(rc));
        write_reg(REG_END_A, CFG_DATA_BITS'(ka));
        write_reg(REG_END_B, CFG_DATA_BITS'(kb));
        write_reg(REG_END_C, CFG_DATA_BITS'(kc));
        write_reg(REG_EXPO, ex);
        write_reg(REG_UNUSED, CFG_DATA_BITS'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [FIELD_BITS-1:0] rand_field();
        return FIELD_BITS'($urandom);
    endfunction

    task automatic load_random_setting();
        logic [FIELD_BITS-1:0] r [NUM_PHASES];
        logic [FIELD_BITS-1:0] k [NUM_PHASES];
        logic [CFG_DATA_BITS-1:0] ex;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < NUM_PHASES; i++) begin
            case (mode)
                0:       r[i] = '0;
                1:       r[i] = rand_field();
                2:       r[i] = FIELD_BITS'($urandom_range(ONE_Q / 2, ONE_Q));
                default: r[i] = FIELD_BITS'($urandom_range(20000));
            endcase
            case ($urandom_range(4))
                0:       k[i] = '0;
                1:       k[i] = Q_ONE;
                2:       k[i] = rand_field();
                default: k[i] = FIELD_BITS'($urandom_range(ONE_Q));
            endcase
        end
        case ($urandom_range(5))
            0:       ex = '0;
            1:       ex = '1;
            2:       ex = EXPO_RESET;
            default: ex = CFG_DATA_BITS'({$urandom, $urandom});
        endcase
        load_setting(r[0], r[1], r[2], k[0], k[1], k[2], ex);
    endtask

    // Mostly physical cells, some on thresholds, some out of range
    task automatic send_random_cell();
        logic [FIELD_BITS-1:0] sa, sb;
        case ($urandom_range(19))
            0, 1: begin
                sa = rand_field();
                sb = rand_field();
            end
            2: begin
                sa = res_q[0] + FIELD_BITS'($urandom_range(2)) - 1'b1;
                sb = FIELD_BITS'($urandom_range(ONE_Q));
            end
            3: begin
                sa = FIELD_BITS'($urandom_range(ONE_Q));
                sb = Q_ONE - res_q[0] - res_q[2] + FIELD_BITS'($urandom_range(2)) - 1'b1;
            end
            default: begin
                sa = FIELD_BITS'($urandom_range(ONE_Q));
                sb = FIELD_BITS'($urandom_range(ONE_Q - sa));
            end
        endcase
        send_cell(sa, sb);
    endtask

    // Register defaults after reset
    task automatic test_reset_defaults();
        send_cell('0, '0);
        send_cell(Q_ONE, '0);
        send_cell('0, Q_ONE);
        send_cell(FIELD_BITS'(ONE_Q / 2), FIELD_BITS'(ONE_Q / 4));
        drain();
    endtask

    // Field extremes, exact thresholds, negative phase c, invalid residuals
    task automatic test_directed();
        load_setting(FIELD_BITS'(6554), FIELD_BITS'(9830), FIELD_BITS'(3277),
                     FIELD_BITS'(52000), Q_ONE, FIELD_BITS'(30000), 48'h1800_3000_2000);
        send_cell('0, '0);
        send_cell('1, '1);
        send_cell(FIELD_BITS'(6554), FIELD_BITS'(9830));
        send_cell(FIELD_BITS'(6555), FIELD_BITS'(9831));
        send_cell(Q_ONE - FIELD_BITS'(13107), FIELD_BITS'(1000));
        send_cell(Q_ONE - FIELD_BITS'(13108), FIELD_BITS'(1000));
        send_cell(FIELD_BITS'(40000), FIELD_BITS'(30000));
        send_cell(FIELD_BITS'(20000), FIELD_BITS'(ONE_Q - 26215));
        send_cell(FIELD_BITS'(20000), FIELD_BITS'(ONE_Q - 26216));
        send_cell(FIELD_BITS'(6555), FIELD_BITS'(ONE_Q - 6555 - 3278));
        send_cell(Q_ONE, Q_ONE);
        drain();
        // Residuals summing to exactly one
        load_setting(FIELD_BITS'(20000), FIELD_BITS'(20000), FIELD_BITS'(ONE_Q - 40000),
                     Q_ONE, Q_ONE, Q_ONE, EXPO_RESET);
        send_cell(FIELD_BITS'(30000), FIELD_BITS'(25000));
        send_cell(Q_ONE, '0);
        drain();
        // Zero and maximum exponents, oversized endpoints
        load_setting('0, '0, '0, '1, '1, '1, 48'h0000_FFFF_0000);
        send_cell(FIELD_BITS'(1), FIELD_BITS'(1));
        send_cell(FIELD_BITS'(ONE_Q / 2), FIELD_BITS'(ONE_Q / 2 - 1));
        send_cell(FIELD_BITS'(ONE_Q - 1), FIELD_BITS'(0));
        send_cell(FIELD_BITS'(1), FIELD_BITS'(ONE_Q - 2));
        drain();
    endtask

    // Random cells across several settings and idling phases
    task automatic test_random_traffic(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        load_random_setting();
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain();
                load_random_setting();
            end
            send_random_cell();
        end
        drain();
    endtask

    // Long receiver hold-off while cells keep coming, so the input stalls
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        load_random_setting();
        hold_cnt = 300;
        repeat (150) send_random_cell();
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        res_q       = '{default: '0};
        kmax_q      = '{default: Q_ONE};
        expo_q      = EXPO_RESET;
        build_roots();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed();
        for (int round = 0; round < 2; round++) begin
            test_random_traffic(0, 0, 90);
            test_random_traffic(72, 0, 80);
            test_random_traffic(0, 72, 80);
            test_random_traffic(31, 31, 90);
        end
        test_backpressure();
        load_setting('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, EXPO_RESET);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/corey_pkg.sv
design/corey_div.sv
design/corey_log.sv
design/corey_exp.sv
design/three_phase_corey_rel_perm_core.sv
design/corey_check.sv
sim/testbench.sv
